[design/ortu_pkg.sv]
// Shared types and constants of the occupancy grid ray trace update block.
`default_nettype none
package ortu_pkg;

   localparam int GRID_SIDE_DEF = 256;
   localparam int CELL_BITS_DEF = 16;

   localparam int COORD_W = 8;
   localparam int VAL_W   = 16;
   localparam int COUNT_W = 9;

   localparam logic signed [VAL_W-1:0] OCC_INC_RST   = 16'sd217;
   localparam logic signed [VAL_W-1:0] FREE_INC_RST  = -16'sd217;
   localparam logic signed [VAL_W-1:0] FLOOR_RST     = -16'sd1280;
   localparam logic signed [VAL_W-1:0] CEILING_RST   = 16'sd1280;

   typedef enum logic [1:0] {
      CSR_OCC_INC  = 2'd0,
      CSR_FREE_INC = 2'd1,
      CSR_FLOOR    = 2'd2,
      CSR_CEILING  = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_TRACE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_QUERY_RD,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic query_rd;
      logic step;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic in_range;
      logic at_end;
   } status_type;

endpackage
`default_nettype wire

[design/ortu_ctrl.sv]
// Sequencer of the ray trace update: clearing pass, item dispatch, query read, walk and result hand-off.
`default_nettype none
module ortu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                rsp_stall,
   output      logic                rsp_valid,
   input  wire ortu_pkg::status_type status,
   output      ortu_pkg::cmd_type    cmd
);
   import ortu_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!status.in_range)    state_in = ST_DONE;
            else if (status.is_query) state_in = ST_QUERY_RD;
            else                      state_in = ST_WALK;
         end
         ST_QUERY_RD: state_in = ST_DONE;
         ST_WALK: begin
            if (status.at_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_CLEAR:    cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_QUERY_RD: cmd.query_rd = 1'b1;
         ST_WALK:     cmd.step = 1'b1;
         ST_DONE:     cmd.rsp_load = out_free;
         default:     cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[design/ortu_dpath.sv]
// Datapath: settings, line walker, grid memory with read-modify-write stage, result register.
`default_nettype none
module ortu_dpath #(
   parameter int GRID_SIDE = ortu_pkg::GRID_SIDE_DEF,
   parameter int CELL_BITS = ortu_pkg::CELL_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ortu_pkg::cmd_type                      cmd,
   output      ortu_pkg::status_type                   status,
   input  wire logic                                   csr_valid,
   input  wire ortu_pkg::csr_index_type                csr_index,
   input  wire logic signed [ortu_pkg::VAL_W-1:0]      csr_wdata,
   input  wire logic                                   req_mode,
   input  wire logic [ortu_pkg::COORD_W-1:0]           req_start_x,
   input  wire logic [ortu_pkg::COORD_W-1:0]           req_start_y,
   input  wire logic [ortu_pkg::COORD_W-1:0]           req_end_x,
   input  wire logic [ortu_pkg::COORD_W-1:0]           req_end_y,
   output      logic                                   rsp_occupied,
   output      logic signed [ortu_pkg::VAL_W-1:0]      rsp_cell_value,
   output      logic [ortu_pkg::COUNT_W-1:0]           rsp_cells_updated
);
   import ortu_pkg::*;

   // only coordinates below 256 can be addressed
   localparam int COORD_SPAN = 1 << COORD_W;
   localparam int SIDE_USED  = (GRID_SIDE < COORD_SPAN) ? GRID_SIDE : COORD_SPAN;
   localparam int DEPTH      = SIDE_USED * SIDE_USED;
   localparam int AW         = $clog2(DEPTH);
   localparam int SW         = ((CELL_BITS > VAL_W) ? CELL_BITS : VAL_W) + 2;
   localparam int ERR_W      = COORD_W + 4;
   localparam logic [COORD_W:0] SIDE_LIM = (COORD_W+1)'(SIDE_USED);
   localparam logic signed [SW-1:0] CELL_HI =
      {{(SW-CELL_BITS+1){1'b0}}, {(CELL_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] CELL_LO = ~CELL_HI;

   // settings
   logic signed [VAL_W-1:0] occ_inc_ff, free_inc_ff, floor_ff, ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_inc_ff  <= OCC_INC_RST;
         free_inc_ff <= FREE_INC_RST;
         floor_ff    <= FLOOR_RST;
         ceiling_ff  <= CEILING_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OCC_INC:  occ_inc_ff  <= csr_wdata;
            CSR_FREE_INC: free_inc_ff <= csr_wdata;
            CSR_FLOOR:    floor_ff    <= csr_wdata;
            CSR_CEILING:  ceiling_ff  <= csr_wdata;
            default:      occ_inc_ff  <= occ_inc_ff;
         endcase
      end
   end

   // item capture and line walker
   logic                    mode_ff;
   logic [COORD_W-1:0]      x_ff, y_ff, x1_ff, y1_ff;
   logic                    sx_neg_ff, sy_neg_ff;
   logic signed [ERR_W-1:0] dx_ff, dy_ff, err_ff;
   logic signed [ERR_W-1:0] dx_in, dy_in, e2, err_in;
   logic [COORD_W-1:0]      adx, ady;
   logic [COUNT_W-1:0]      count_ff;
   logic                    at_end, move_x, move_y;

   assign adx   = (req_end_x > req_start_x) ? req_end_x - req_start_x
                                            : req_start_x - req_end_x;
   assign ady   = (req_end_y > req_start_y) ? req_end_y - req_start_y
                                            : req_start_y - req_end_y;
   assign dx_in = ERR_W'({1'b0, adx});
   assign dy_in = -ERR_W'({1'b0, ady});

   assign at_end = (x_ff == x1_ff) && (y_ff == y1_ff);
   assign e2     = err_ff <<< 1;
   assign move_x = (e2 >= dy_ff);
   assign move_y = (e2 <= dx_ff);
   assign err_in = err_ff + (move_x ? dy_ff : ERR_W'(0)) + (move_y ? dx_ff : ERR_W'(0));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         x_ff      <= req_start_x;
         y_ff      <= req_start_y;
         x1_ff     <= req_end_x;
         y1_ff     <= req_end_y;
         sx_neg_ff <= !(req_start_x < req_end_x);
         sy_neg_ff <= !(req_start_y < req_end_y);
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         err_ff    <= dx_in + dy_in;
         count_ff  <= '0;
      end else if (cmd.step) begin
         count_ff <= count_ff + COUNT_W'(1);
         if (!at_end) begin
            err_ff <= err_in;
            if (move_x) x_ff <= sx_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
            if (move_y) y_ff <= sy_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
         end
      end
   end

   logic start_ok, end_ok, in_range;
   assign start_ok = ({1'b0, x_ff} < SIDE_LIM) && ({1'b0, y_ff} < SIDE_LIM);
   assign end_ok   = ({1'b0, x1_ff} < SIDE_LIM) && ({1'b0, y1_ff} < SIDE_LIM);
   assign in_range = (mode_ff == MODE_QUERY) ? start_ok : (start_ok && end_ok);

   // clearing pass
   logic [AW-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset)          clr_addr_ff <= '0;
      else if (cmd.clear) clr_addr_ff <= clr_addr_ff + AW'(1);
   end

   assign status.clear_last = (clr_addr_ff == AW'(DEPTH - 1));
   assign status.is_query   = (mode_ff == MODE_QUERY);
   assign status.in_range   = in_range;
   assign status.at_end     = at_end;

   // grid memory: read at the walker cell, write back in the next cycle
   logic [CELL_BITS-1:0] grid_mem [DEPTH];
   logic [CELL_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        cur_addr, wr_addr;
   logic                 rd_en, wr_en;
   logic [CELL_BITS-1:0] wr_data;
   logic                 wb_valid_ff;
   logic [AW-1:0]        wb_addr_ff;
   logic signed [VAL_W-1:0] wb_inc_ff;

   assign cur_addr = AW'(32'(y_ff) * SIDE_USED + 32'(x_ff));
   assign rd_en    = cmd.step || cmd.query_rd;

   always_ff @(posedge clock) begin
      if (reset) wb_valid_ff <= 1'b0;
      else       wb_valid_ff <= cmd.step;
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         wb_addr_ff <= cur_addr;
         wb_inc_ff  <= at_end ? occ_inc_ff : free_inc_ff;
      end
   end

   // saturating update of the cell read back
   logic signed [SW-1:0] cell_ext, sum, s_floor, s_ceil, s_hi, s_lo;
   logic signed [SW-1:0] floor_ext, ceiling_ext;

   assign cell_ext    = SW'($signed(rd_data_ff));
   assign floor_ext   = SW'(floor_ff);
   assign ceiling_ext = SW'(ceiling_ff);
   assign sum         = cell_ext + SW'(wb_inc_ff);
   assign s_floor     = (sum < floor_ext) ? floor_ext : sum;
   assign s_ceil      = (s_floor > ceiling_ext) ? ceiling_ext : s_floor;
   assign s_hi        = (s_ceil > CELL_HI) ? CELL_HI : s_ceil;
   assign s_lo        = (s_hi < CELL_LO) ? CELL_LO : s_hi;

   assign wr_en   = cmd.clear || wb_valid_ff;
   assign wr_addr = cmd.clear ? clr_addr_ff : wb_addr_ff;
   assign wr_data = cmd.clear ? '0 : CELL_BITS'(s_lo);

   always_ff @(posedge clock) begin
      if (wr_en) grid_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= grid_mem[cur_addr];
   end

   // result
   logic                    occ_in;
   logic signed [SW-1:0]    mid_sum;
   logic                    res_occ;
   logic signed [VAL_W-1:0] res_val;
   logic [COUNT_W-1:0]      res_cnt;

   assign mid_sum = floor_ext + ceiling_ext;
   assign occ_in  = (floor_ff < ceiling_ff) && ((cell_ext <<< 1) > mid_sum);

   always_comb begin
      res_occ = 1'b0;
      res_val = '0;
      res_cnt = '0;
      if (in_range) begin
         if (mode_ff == MODE_QUERY) begin
            res_occ = occ_in;
            res_val = cell_ext[VAL_W-1:0];
         end else begin
            res_cnt = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_occupied      <= res_occ;
         rsp_cell_value    <= res_val;
         rsp_cells_updated <= res_cnt;
      end
   end

endmodule
`default_nettype wire

[design/occupancy_ray_trace_update_top.sv]
// Top level of the occupancy grid ray trace update block.
`default_nettype none
// Keeps a grid of signed log-odds cells and updates it along Bresenham lines.
// After reset the block runs a clearing pass of one cell a cycle over
// min(GRID_SIDE,256)^2 cells (65536 at the defaults) and holds
// req_stall high meanwhile; settings writes are taken at any time
// (csr_ready is always high). A trace beat updates every cell on the
// line (at most 256 cells): the grid memory has one read and one write
// port, so each cell is read and then written back in the next cycle
// while the walker already reads the following cell. A query reads its
// one cell; an off-grid item goes straight to the result. One item is in
// work at a time; the next one is accepted while the previous result
// still waits in the output register.
module occupancy_ray_trace_update_top #(
   parameter int GRID_SIDE = ortu_pkg::GRID_SIDE_DEF,
   parameter int CELL_BITS = ortu_pkg::CELL_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_mode,
   input  wire logic [ortu_pkg::COORD_W-1:0]      req_start_x,
   input  wire logic [ortu_pkg::COORD_W-1:0]      req_start_y,
   input  wire logic [ortu_pkg::COORD_W-1:0]      req_end_x,
   input  wire logic [ortu_pkg::COORD_W-1:0]      req_end_y,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_occupied,
   output      logic signed [ortu_pkg::VAL_W-1:0] rsp_cell_value,
   output      logic [ortu_pkg::COUNT_W-1:0]      rsp_cells_updated,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire ortu_pkg::csr_index_type           csr_index,
   input  wire logic signed [ortu_pkg::VAL_W-1:0] csr_wdata
);
   import ortu_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ortu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ortu_dpath #(
      .GRID_SIDE (GRID_SIDE),
      .CELL_BITS (CELL_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .rsp_occupied      (rsp_occupied),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cells_updated (rsp_cells_updated)
   );

   // at most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.query_rd, cmd.step, cmd.rsp_load}))
      else $error("more than one datapath command at once");

   // a result never overwrites one still waiting
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while occupied");

   // an accepted beat keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a second beat right after the first");

   // the clearing pass never overlaps a ray walk
   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !cmd.clear ##1 !cmd.clear)
      else $error("clearing pass during ray walk");

endmodule
`default_nettype wire
